/* rtl/core/msm_pkg.sv */
// Shared types and constants for the mecanum wheel speed mixer.
// Used by msm_mix, msm_div_cell and mecanum_wheel_speed_mixer_top; depends on nothing.
`timescale 1ns / 1ps

package msm_pkg;

  localparam int unsigned CmdW      = 16;  // width of one velocity command field
  localparam int unsigned LimW      = 15;  // width of the speed limit register
  localparam int unsigned SumW      = 18;  // signed raw wheel sum, never wraps
  localparam int unsigned MagW      = 17;  // magnitude of a raw sum, up to 98304
  localparam int unsigned NumW      = 32;  // dividend: magnitude times limit
  localparam int unsigned QuoW      = 15;  // quotient never exceeds the limit
  localparam int unsigned NumWheels = 4;

  localparam logic [LimW-1:0] LimitReset = 15'd10000;

  // Wheel lane order inside the datapath.
  localparam int unsigned WheelFl = 0;
  localparam int unsigned WheelFr = 1;
  localparam int unsigned WheelBl = 2;
  localparam int unsigned WheelBr = 3;

  typedef struct packed {
    logic signed [CmdW-1:0] vel_forward;
    logic signed [CmdW-1:0] vel_side;
    logic signed [CmdW-1:0] vel_turn;
  } vel_cmd_t;

  typedef struct packed {
    logic signed [CmdW-1:0] wheel_front_left;
    logic signed [CmdW-1:0] wheel_front_right;
    logic signed [CmdW-1:0] wheel_back_left;
    logic signed [CmdW-1:0] wheel_back_right;
    logic                   was_scaled;
  } wheel_out_t;

  // One wheel as it travels down the divider chain.
  typedef struct packed {
    logic            neg;
    logic [NumW-1:0] rem;
    logic [QuoW-1:0] quo;
  } lane_t;

  typedef struct packed {
    lane_t [NumWheels-1:0] lane;
    logic  [MagW-1:0]      div;
    logic                  scaled;
  } div_item_t;

endpackage

/* rtl/core/msm_mix.sv */
// Mixing front end: raw wheel sums, magnitudes, the largest magnitude and dividend set-up.
// Two register stages with a valid/ready handshake; depends on msm_pkg.
`timescale 1ns / 1ps

module msm_mix (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [msm_pkg::LimW-1:0]  lim_i,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  msm_pkg::vel_cmd_t         cmd_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output msm_pkg::div_item_t        item_o
);

  // Stage A holds signs and magnitudes of the four raw sums.
  logic                                                  va_q;
  logic [msm_pkg::NumWheels-1:0]                         neg_q, neg_d;
  logic [msm_pkg::NumWheels-1:0][msm_pkg::MagW-1:0]      mag_q, mag_d;
  logic [msm_pkg::LimW-1:0]                              lim_q;

  // Stage B holds the dividend set-up.
  logic                  vb_q;
  msm_pkg::div_item_t    item_q, item_d;

  logic en_a, en_b;

  logic signed [msm_pkg::SumW-1:0] vx, vy, vw;
  logic signed [msm_pkg::SumW-1:0] sum [msm_pkg::NumWheels];
  logic signed [msm_pkg::SumW-1:0] neg_sum;

  logic [msm_pkg::MagW-1:0] m01, m23, mx;
  logic [msm_pkg::NumW-1:0] prod;
  logic                     scaled;

  assign en_b    = !vb_q || ready_i;
  assign en_a    = !va_q || en_b;
  assign ready_o = en_a;
  assign valid_o = vb_q;
  assign item_o  = item_q;

  always_comb begin
    vx = msm_pkg::SumW'(cmd_i.vel_forward);
    vy = msm_pkg::SumW'(cmd_i.vel_side);
    vw = msm_pkg::SumW'(cmd_i.vel_turn);
    sum[msm_pkg::WheelFl] = vx + vy - vw;
    sum[msm_pkg::WheelFr] = vy - vx - vw;
    sum[msm_pkg::WheelBl] = vx - vy - vw;
    sum[msm_pkg::WheelBr] = -vx - vy - vw;
    neg_sum = '0;
    for (int i = 0; i < msm_pkg::NumWheels; i++) begin
      neg_sum  = -sum[i];
      neg_d[i] = sum[i][msm_pkg::SumW-1];
      mag_d[i] = neg_d[i] ? neg_sum[msm_pkg::MagW-1:0] : sum[i][msm_pkg::MagW-1:0];
    end
  end

  always_comb begin
    m01    = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
    m23    = (mag_q[2] > mag_q[3]) ? mag_q[2] : mag_q[3];
    mx     = (m01 > m23) ? m01 : m23;
    scaled = mx > {2'b00, lim_q};
    prod   = '0;
    item_d = '0;
    item_d.scaled = scaled;
    // Without limiting the divisor is one, so the chain passes the magnitude through.
    item_d.div    = scaled ? mx : msm_pkg::MagW'(1);
    for (int i = 0; i < msm_pkg::NumWheels; i++) begin
      prod = {15'd0, mag_q[i]} * {17'd0, lim_q};
      item_d.lane[i].neg = neg_q[i];
      item_d.lane[i].rem = scaled ? prod : {15'd0, mag_q[i]};
      item_d.lane[i].quo = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) va_q <= valid_i;
      if (en_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && valid_i) begin
      neg_q <= neg_d;
      mag_q <= mag_d;
      lim_q <= lim_i;
    end
    if (en_b && va_q) begin
      item_q <= item_d;
    end
  end

  // The dividend must stay below the divisor times two to the quotient width.
  logic num_ok;
  always_comb begin
    num_ok = 1'b1;
    for (int i = 0; i < msm_pkg::NumWheels; i++) begin
      if ({1'b0, item_q.lane[i].rem} >= ({16'd0, item_q.div} << msm_pkg::QuoW)) num_ok = 1'b0;
    end
  end

  a_num_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q |-> num_ok)
    else $error("dividend out of range for the divider chain");

  a_unscaled_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vb_q && !item_q.scaled) |-> (item_q.div == msm_pkg::MagW'(1)))
    else $error("pass-through item has a divisor other than one");

endmodule

/* rtl/core/msm_div_cell.sv */
// One cell of the restoring divider chain: resolves one quotient bit for all four wheels.
// Registered output with a valid/ready handshake; depends on msm_pkg.
`timescale 1ns / 1ps

module msm_div_cell #(
  parameter int unsigned BitIdx = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  msm_pkg::div_item_t item_i,
  output logic               valid_o,
  input  logic               ready_i,
  output msm_pkg::div_item_t item_o
);

  logic               v_q;
  msm_pkg::div_item_t item_q, item_d;
  logic               en;

  logic [msm_pkg::NumW:0] dsh;
  logic [msm_pkg::NumW:0] trial;

  assign en      = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;
  assign item_o  = item_q;

  always_comb begin
    item_d = item_i;
    dsh    = (msm_pkg::NumW + 1)'(item_i.div) << BitIdx;
    trial  = '0;
    for (int i = 0; i < msm_pkg::NumWheels; i++) begin
      trial = {1'b0, item_i.lane[i].rem} - dsh;
      item_d.lane[i].quo[BitIdx] = !trial[msm_pkg::NumW];
      if (!trial[msm_pkg::NumW]) begin
        item_d.lane[i].rem = trial[msm_pkg::NumW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      item_q <= item_d;
    end
  end

  // After this cell every partial remainder is below the divisor at this bit weight.
  logic rem_ok;
  always_comb begin
    rem_ok = 1'b1;
    for (int i = 0; i < msm_pkg::NumWheels; i++) begin
      if ({1'b0, item_q.lane[i].rem} >= ((msm_pkg::NumW + 1)'(item_q.div) << BitIdx)) begin
        rem_ok = 1'b0;
      end
    end
  end

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> rem_ok)
    else $error("partial remainder not reduced below the divisor");

endmodule

/* rtl/core/mecanum_wheel_speed_mixer_top.sv */
// Top level of the mecanum wheel speed mixer: limit register, mixer, divider chain, output.
// Depends on msm_pkg, msm_mix and msm_div_cell.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake                     Payload
//  cmd       in         cmd_valid_i / cmd_ready_o     cmd_i   (vel_cmd_t)
//  wheel     out        wheel_valid_o / wheel_ready_i wheel_o (wheel_out_t)
//  cfg       in         cfg_we_i                      cfg_wdata_i (speed limit)
//
//  An accepted item passes two mixer stages, then one cell per quotient bit (15), and then
//  the output stage, which is the output register; each of these is one register.
//  One item enters per cycle unless back-pressure from the output has filled the pipeline.
//  Reset clears every valid flag and loads the speed limit with 10000.
//  Each stage advances when it is empty or its successor advances, so bubbles close up and
//  new items are taken while a finished result waits at the output.

module mecanum_wheel_speed_mixer_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  output logic                     cmd_ready_o,
  input  msm_pkg::vel_cmd_t        cmd_i,
  output logic                     wheel_valid_o,
  input  logic                     wheel_ready_i,
  output msm_pkg::wheel_out_t      wheel_o,
  input  logic                     cfg_we_i,
  input  logic [msm_pkg::LimW-1:0] cfg_wdata_i
);

  // The speed limit register. The user must rewrite it only while no item is in flight; the
  // block does not enforce this, and the mixer also captures it alongside each item.
  logic [msm_pkg::LimW-1:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= msm_pkg::LimitReset;
    end else if (cfg_we_i) begin
      lim_q <= cfg_wdata_i;
    end
  end

  // Chain links: link 0 comes out of the mixer, link QuoW feeds the output stage.
  logic               chain_v [msm_pkg::QuoW+1];
  logic               chain_r [msm_pkg::QuoW+1];
  msm_pkg::div_item_t chain_d [msm_pkg::QuoW+1];

  // The mixer forms the raw sums, finds the largest magnitude and decides on scaling.
  // A scaled wheel enters the chain as magnitude times limit over the largest magnitude;
  // an unscaled one enters with divisor one and so leaves the chain unchanged.
  msm_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .lim_i   (lim_q),
    .valid_i (cmd_valid_i),
    .ready_o (cmd_ready_o),
    .cmd_i   (cmd_i),
    .valid_o (chain_v[0]),
    .ready_i (chain_r[0]),
    .item_o  (chain_d[0])
  );

  // Restoring divider laid out as a row of cells, most significant quotient bit first.
  // The quotient never exceeds the limit, so fifteen bits cover it.
  for (genvar k = 0; k < msm_pkg::QuoW; k++) begin : g_div
    msm_div_cell #(
      .BitIdx (msm_pkg::QuoW - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_v[k]),
      .ready_o (chain_r[k]),
      .item_i  (chain_d[k]),
      .valid_o (chain_v[k+1]),
      .ready_i (chain_r[k+1]),
      .item_o  (chain_d[k+1])
    );
  end

  // Output stage: put the sign back on each quotient and hold the result item until taken.
  logic                 out_v_q;
  msm_pkg::wheel_out_t  out_q, out_d;
  logic                 out_en;
  logic signed [msm_pkg::CmdW-1:0] wheel_val [msm_pkg::NumWheels];
  logic        [msm_pkg::CmdW-1:0] quo_ext;

  assign out_en                = !out_v_q || wheel_ready_i;
  assign chain_r[msm_pkg::QuoW] = out_en;
  assign wheel_valid_o         = out_v_q;
  assign wheel_o               = out_q;

  always_comb begin
    quo_ext = '0;
    for (int i = 0; i < msm_pkg::NumWheels; i++) begin
      quo_ext      = {1'b0, chain_d[msm_pkg::QuoW].lane[i].quo};
      wheel_val[i] = chain_d[msm_pkg::QuoW].lane[i].neg ? -quo_ext : quo_ext;
    end
    out_d.wheel_front_left  = wheel_val[msm_pkg::WheelFl];
    out_d.wheel_front_right = wheel_val[msm_pkg::WheelFr];
    out_d.wheel_back_left   = wheel_val[msm_pkg::WheelBl];
    out_d.wheel_back_right  = wheel_val[msm_pkg::WheelBr];
    out_d.was_scaled        = chain_d[msm_pkg::QuoW].scaled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= chain_v[msm_pkg::QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && chain_v[msm_pkg::QuoW]) begin
      out_q <= out_d;
    end
  end

  // Every delivered wheel speed lies within plus or minus the speed limit.
  logic signed [msm_pkg::CmdW:0] lim_s;
  logic                          within_lim;
  logic signed [msm_pkg::CmdW:0] chk [msm_pkg::NumWheels];

  always_comb begin
    lim_s  = {2'b00, lim_q};
    chk[0] = (msm_pkg::CmdW + 1)'(out_q.wheel_front_left);
    chk[1] = (msm_pkg::CmdW + 1)'(out_q.wheel_front_right);
    chk[2] = (msm_pkg::CmdW + 1)'(out_q.wheel_back_left);
    chk[3] = (msm_pkg::CmdW + 1)'(out_q.wheel_back_right);
    within_lim = 1'b1;
    for (int i = 0; i < msm_pkg::NumWheels; i++) begin
      if (chk[i] > lim_s || chk[i] < -lim_s) within_lim = 1'b0;
    end
  end

  a_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> within_lim)
    else $error("wheel speed beyond the configured limit");

endmodule
